// ----- sv/srp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and codes of the skyline rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

    // Result status codes.
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] REG_BIN_WIDTH  = 1'b0;
    localparam logic [0:0] REG_BIN_HEIGHT = 1'b1;

    // One skyline segment as held in the segment memory.
    typedef struct packed {
        logic [14:0] x;
        logic [14:0] top;
        logic [15:0] span;
    } seg_t;

endpackage

// ----- sv/srp_seg_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_seg_mem
// Segment store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module srp_seg_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  srp_pkg::seg_t    wr_data,
    input  logic [AW-1:0]    rd_addr,
    output srp_pkg::seg_t    rd_data
);
    import srp_pkg::*;

    seg_t mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/srp_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_engine
// Search and update sequencer. It scans the segment memory for the best
// position, then rebuilds the skyline by streaming from the memory into the
// same memory with a read pointer that runs ahead of the write pointer.
// ----------------------------------------------------------------------------
module srp_engine #(
    parameter int MAX_SEGMENTS = 256,
    parameter int AW = 8,
    parameter int CW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  logic [14:0]   bin_width,
    input  logic [14:0]   bin_height,
    input  logic          start,
    input  logic [14:0]   req_w,
    input  logic [14:0]   req_h,
    input  logic          req_rot,
    output logic          idle,
    output logic          done,
    output logic [1:0]    res_status,
    output logic [14:0]   res_x_min,
    output logic [14:0]   res_y_min,
    output logic [14:0]   res_x_max,
    output logic [14:0]   res_y_max,
    output logic          res_rotated
);
    import srp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OUTRD = 4'd1;   // read the start segment
    localparam logic [3:0] S_OUTW  = 4'd2;   // start segment data ready
    localparam logic [3:0] S_WALK  = 4'd3;   // walk following segments
    localparam logic [3:0] S_NEXT  = 4'd4;   // choose next candidate
    localparam logic [3:0] S_UPRD  = 4'd5;   // update: consume and write
    localparam logic [3:0] S_UPW   = 4'd6;   // update: wait for the read data
    localparam logic [3:0] S_FLUSH = 4'd7;   // write out the held segment
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cand_reg, cand_next;      // candidate start index
    logic [CW-1:0] walk_reg, walk_next;      // walk index
    logic          try_rot_reg, try_rot_next;
    logic [14:0]   sw_reg, sw_next, sh_reg, sh_next;
    logic [15:0]   left_reg, left_next;
    logic [14:0]   y_reg, y_next;
    logic [14:0]   cx_reg, cx_next;
    logic [15:0]   cspan_reg, cspan_next;
    logic          found_reg, found_next;
    logic [15:0]   btop_reg, btop_next;
    logic [15:0]   bspan_reg, bspan_next;
    logic [CW-1:0] bidx_reg, bidx_next;
    logic [14:0]   bx_reg, bx_next, by_reg, by_next, bw_reg, bw_next, bh_reg, bh_next;
    logic          brot_reg, brot_next;
    // Update streaming.
    logic [CW-1:0] rp_reg, rp_next;          // next source index to read
    logic [CW-1:0] wp_reg, wp_next;          // next destination index
    logic          hold_v_reg, hold_v_next;  // a merged segment waits to be written
    seg_t          hold_reg, hold_next;
    logic          ins_reg, ins_next;        // new segment already inserted
    logic [1:0]    st_reg, st_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    seg_t          wr_data, rd_data;
    logic          rst_wr_reg;

    srp_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= CW'(1);
            rst_wr_reg <= 1'b1;
        end
        else if (restart)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= CW'(1);
            rst_wr_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rst_wr_reg <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;  walk_reg <= walk_next; try_rot_reg <= try_rot_next;
        sw_reg <= sw_next;  sh_reg <= sh_next;  left_reg <= left_next;
        y_reg <= y_next;    cx_reg <= cx_next;  cspan_reg <= cspan_next;
        found_reg <= found_next; btop_reg <= btop_next; bspan_reg <= bspan_next;
        bidx_reg <= bidx_next; bx_reg <= bx_next; by_reg <= by_next;
        bw_reg <= bw_next; bh_reg <= bh_next; brot_reg <= brot_next;
        rp_reg <= rp_next; wp_reg <= wp_next; hold_v_reg <= hold_v_next;
        hold_reg <= hold_next; ins_reg <= ins_next; st_reg <= st_next;
    end

    // Fit-test arithmetic on the segment being walked.
    logic [14:0] walk_y;
    logic [15:0] y_plus_h;
    logic [15:0] cand_top;
    logic        better;
    assign walk_y   = (rd_data.top > y_reg) ? rd_data.top : y_reg;
    assign y_plus_h = {1'b0, walk_y} + {1'b0, sh_reg};
    assign cand_top = y_plus_h;
    assign better   = !found_reg || (cand_top < btop_reg) ||
                      ((cand_top == btop_reg) && (cspan_reg < bspan_reg));

    // Update stage: the segment that enters the merge stream this cycle.
    seg_t        src_seg;
    seg_t        new_seg;
    logic [15:0] new_end;
    logic [15:0] src_end;
    seg_t        trimmed;
    logic        drop_src;
    assign new_seg = '{x: bx_reg, top: 15'(by_reg + bh_reg), span: {1'b0, bw_reg}};
    assign new_end = {1'b0, bx_reg} + {1'b0, bw_reg};
    assign src_end = {1'b0, rd_data.x} + rd_data.span;
    always_comb
    begin
        trimmed  = rd_data;
        drop_src = 1'b0;
        // Segments after the new one lose what it covers.
        if (ins_reg && ({1'b0, rd_data.x} < new_end))
        begin
            if (src_end <= new_end)
            begin
                drop_src = 1'b1;
            end
            else
            begin
                trimmed.x    = new_end[14:0];
                trimmed.span = src_end - new_end;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;  count_next = count_reg;
        cand_next = cand_reg; walk_next = walk_reg; try_rot_next = try_rot_reg;
        sw_next = sw_reg; sh_next = sh_reg; left_next = left_reg; y_next = y_reg;
        cx_next = cx_reg; cspan_next = cspan_reg; found_next = found_reg;
        btop_next = btop_reg; bspan_next = bspan_reg; bidx_next = bidx_reg;
        bx_next = bx_reg; by_next = by_reg; bw_next = bw_reg; bh_next = bh_reg;
        brot_next = brot_reg; rp_next = rp_reg; wp_next = wp_reg;
        hold_v_next = hold_v_reg; hold_next = hold_reg; ins_next = ins_reg;
        st_next = st_reg;
        wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = cand_reg[AW-1:0];
        src_seg = '0;

        // After restart the single full-width segment is written to entry 0.
        if (rst_wr_reg)
        begin
            wr_en   = 1'b1;
            wr_data = '{x: 15'd0, top: 15'd0, span: {1'b0, bin_width}};
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    found_next = 1'b0; cand_next = '0; try_rot_next = 1'b0;
                    sw_next = req_w; sh_next = req_h;
                    st_next = ST_NOFIT;
                    if (req_w == '0 || req_h == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_OUTRD;
                    end
                end
            end
            S_OUTRD:
            begin
                rd_addr    = cand_reg[AW-1:0];
                state_next = S_OUTW;
            end
            S_OUTW:
            begin
                // Start of a fit test at the candidate segment.
                cx_next    = rd_data.x;
                cspan_next = rd_data.span;
                y_next     = rd_data.top;
                left_next  = {1'b0, sw_reg};
                walk_next  = cand_reg;
                if (({1'b0, rd_data.x} + {1'b0, sw_reg}) > {1'b0, bin_width})
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    rd_addr    = cand_reg[AW-1:0];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // rd_data holds segment walk_reg.
                if (y_plus_h > {1'b0, bin_height})
                begin
                    state_next = S_NEXT;
                end
                else if (rd_data.span >= left_reg)
                begin
                    if (better)
                    begin
                        found_next = 1'b1; btop_next = cand_top; bspan_next = cspan_reg;
                        bidx_next = cand_reg; bx_next = cx_reg; by_next = walk_y;
                        bw_next = sw_reg; bh_next = sh_reg; brot_next = try_rot_reg;
                    end
                    state_next = S_NEXT;
                end
                else
                begin
                    y_next    = walk_y;
                    left_next = left_reg - rd_data.span;
                    walk_next = walk_reg + CW'(1);
                    if ((walk_reg + CW'(1)) >= count_reg)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        rd_addr = AW'(walk_reg + CW'(1));
                    end
                end
            end
            S_NEXT:
            begin
                if (!try_rot_reg && req_rot)
                begin
                    try_rot_next = 1'b1; sw_next = req_h; sh_next = req_w;
                    state_next = S_OUTRD;
                end
                else if ((cand_reg + CW'(1)) < count_reg)
                begin
                    try_rot_next = 1'b0; sw_next = req_w; sh_next = req_h;
                    cand_next = cand_reg + CW'(1);
                    state_next = S_OUTRD;
                end
                else if (!found_reg)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg >= CW'(MAX_SEGMENTS))
                begin
                    st_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    // Rebuild from entry 0; rp leads wp so no entry is overwritten early.
                    st_next = ST_PLACED;
                    rp_next = '0; wp_next = '0; hold_v_next = 1'b0; ins_next = 1'b0;
                    rd_addr = '0;
                    state_next = S_UPRD;
                end
            end
            S_UPRD:
            begin
                // rd_data is the entry rp_reg; or the new segment at its slot.
                if (!ins_reg && rp_reg == bidx_reg)
                begin
                    src_seg = new_seg;
                    ins_next = 1'b1;
                end
                else
                begin
                    src_seg = trimmed;
                    rp_next = rp_reg + CW'(1);
                end
                if (!(ins_reg && drop_src) || (!ins_reg && rp_reg == bidx_reg))
                begin
                    if (hold_v_reg && hold_reg.top == src_seg.top)
                    begin
                        hold_next.span = hold_reg.span + src_seg.span;
                    end
                    else
                    begin
                        if (hold_v_reg)
                        begin
                            wr_en = 1'b1; wr_addr = wp_reg[AW-1:0]; wr_data = hold_reg;
                            wp_next = wp_reg + CW'(1);
                        end
                        hold_next = src_seg; hold_v_next = 1'b1;
                    end
                end
                rd_addr = (!ins_reg && rp_reg == bidx_reg) ? rp_reg[AW-1:0]
                                                           : AW'(rp_reg + CW'(1));
                if ((!ins_reg && rp_reg == bidx_reg) ? 1'b0 : ((rp_reg + CW'(1)) >= count_reg))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_UPW;
                end
            end
            S_UPW:
            begin
                // Read data for the new rp is ready in the next cycle; wait here for it.
                rd_addr    = rp_reg[AW-1:0];
                state_next = S_UPRD;
            end
            S_FLUSH:
            begin
                wr_en = 1'b1; wr_addr = wp_reg[AW-1:0]; wr_data = hold_reg;
                count_next = wp_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The reads in S_UPRD use the address issued in the cycle before, so the
    // read pointer never passes a location that still waits to be written.
    assign idle        = (state_reg == S_IDLE);
    assign done        = (state_reg == S_DONE);
    assign res_status  = st_reg;
    assign res_x_min   = (st_reg == ST_PLACED) ? bx_reg : '0;
    assign res_y_min   = (st_reg == ST_PLACED) ? by_reg : '0;
    assign res_x_max   = (st_reg == ST_PLACED) ? 15'(bx_reg + bw_reg) : '0;
    assign res_y_max   = (st_reg == ST_PLACED) ? 15'(by_reg + bh_reg) : '0;
    assign res_rotated = (st_reg == ST_PLACED) ? brot_reg : 1'b0;

    // The skyline never holds zero or more than the store's entries.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CW'(MAX_SEGMENTS)))
        else $error("segment count out of range");
    // The write pointer never runs more than one entry ahead of the read pointer during rebuild.
    a_wp_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPRD) |-> (wp_reg <= rp_reg + CW'(1)))
        else $error("rebuild write pointer ahead of read pointer");
    // A placed result always comes with a found candidate.
    a_placed_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_status == ST_PLACED) |-> found_reg)
        else $error("placed without candidate");

endmodule

// ----- sv/skyline_rect_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_rect_packer
// Skyline bottom-left rectangle packer with a memory-held segment list.
// Each request runs a fit test per shape and start segment, walking the segments
// it covers, then rebuilds the skyline segment by segment.
// One request is handled at a time; the scan of the segment memory sets the rate.
// Reset or any register write restarts the skyline to one segment.
// ----------------------------------------------------------------------------
module skyline_rect_packer #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [14:0] cfg_data,
    // Requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rect_width[14:0], rect_height[29:15], allow_rotation[30]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status, x_min, y_min, x_max, y_max, rotated
);
    import srp_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic [14:0] bin_width_reg, bin_height_reg;
    logic        cfg_wr;
    logic        busy_reg;
    logic        idle, done;
    logic [1:0]  r_status;
    logic [14:0] r_x0, r_y0, r_x1, r_y1;
    logic        r_rot;
    logic [30:0] req_reg;
    logic [30:0] req_cur;
    logic        start;

    // Register writes are taken only while no request is in progress.
    assign cfg_ready = !busy_reg && idle;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_tready  = !busy_reg && !m_tvalid && idle && !cfg_valid;
    assign start     = s_tvalid && s_tready;

    // The request comes from the bus at acceptance and from its register after.
    assign req_cur = start ? s_tdata[30:0] : req_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg  <= '0;
            bin_height_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == REG_BIN_WIDTH)
            begin
                bin_width_reg <= cfg_data;
            end
            else
            begin
                bin_height_reg <= cfg_data;
            end
        end
    end

    // Request holding and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            m_tvalid <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (done)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= s_tdata[30:0];
        end
        if (done)
        begin
            m_tdata <= {1'b0, r_rot, r_y1, r_x1, r_y0, r_x0, r_status};
        end
    end

    srp_engine #(.MAX_SEGMENTS(MAX_SEGMENTS), .AW(AW), .CW(CW)) u_engine (
        .clk(clk), .rst_n(rst_n), .restart(cfg_wr),
        .bin_width(bin_width_reg), .bin_height(bin_height_reg),
        .start(start),
        .req_w(req_cur[14:0]), .req_h(req_cur[29:15]), .req_rot(req_cur[30]),
        .idle(idle), .done(done), .res_status(r_status),
        .res_x_min(r_x0), .res_y_min(r_y0), .res_x_max(r_x1), .res_y_max(r_y1),
        .res_rotated(r_rot)
    );

endmodule

// ----- test/skyline_rect_packer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_rect_packer_tb
// Self-checking bench for the skyline rectangle packer. A directed table walks
// the bin extremes, zero sizes, rotation and no-fit cases, then a store-full fill.
// Random requests on small bins follow under three idling patterns. Each result
// beat is checked against a typed want or a behavioral skyline predictor.
// ----------------------------------------------------------------------------
module skyline_rect_packer_tb;
    import srp_pkg::*;

    localparam int SEG_DEPTH   = 256;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int RAND_ITEMS  = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] x_min;
        logic [14:0] y_min;
        logic [14:0] x_max;
        logic [14:0] y_max;
        logic        rotated;
    } placement_t;

    // One row of the directed table: a register write or a request.
    typedef struct {
        bit          is_cfg;
        logic [0:0]  reg_idx;
        logic [14:0] reg_val;
        logic [14:0] w;
        logic [14:0] h;
        bit          rot;
        bit          typed;
        placement_t  want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // rect_width[14:0], rect_height[29:15], allow_rotation[30]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // status, x_min, y_min, x_max, y_max, rotated

    skyline_rect_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor copy of the skyline and the bin registers.
    int unsigned sky_x [SEG_DEPTH];
    int unsigned sky_top [SEG_DEPTH];
    int unsigned sky_span [SEG_DEPTH];
    int unsigned sky_count;
    int unsigned bin_w;
    int unsigned bin_h;

    placement_t pending_places[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         failed;
    int         cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void restart_sky();
        for (int k = 0; k < SEG_DEPTH; k++)
        begin
            sky_x[k] = 0;
            sky_top[k] = 0;
            sky_span[k] = 0;
        end
        sky_span[0] = bin_w;
        sky_count = 1;
    endfunction

    // Bottom of a w by h shape whose left end sits on segment idx.
    function automatic bit shape_fits(int unsigned idx, int unsigned w, int unsigned h,
                                      output int unsigned bottom);
        int unsigned remain;
        int unsigned k;
        int unsigned y;
        bottom = 0;
        if (sky_x[idx] + w > bin_w)
            return 0;
        remain = w;
        k = idx;
        y = sky_top[idx];
        while (remain > 0)
        begin
            if (k >= sky_count)
                return 0;
            if (sky_top[k] > y)
                y = sky_top[k];
            if (y + h > bin_h)
                return 0;
            if (sky_span[k] >= remain)
                remain = 0;
            else
                remain -= sky_span[k];
            k++;
        end
        bottom = y;
        return 1;
    endfunction

    function automatic void drop_seg(int unsigned idx);
        for (int unsigned k = idx; k + 1 < sky_count; k++)
        begin
            sky_x[k] = sky_x[k + 1];
            sky_top[k] = sky_top[k + 1];
            sky_span[k] = sky_span[k + 1];
        end
        sky_count--;
    endfunction

    // Insert the placed rectangle as a segment, trim what it covers, merge.
    function automatic void raise_sky(int unsigned idx, int unsigned x, int unsigned top,
                                      int unsigned span);
        int unsigned k;
        int unsigned prev_end;
        int unsigned cut;
        for (k = sky_count; k > idx; k--)
        begin
            sky_x[k] = sky_x[k - 1];
            sky_top[k] = sky_top[k - 1];
            sky_span[k] = sky_span[k - 1];
        end
        sky_x[idx] = x;
        sky_top[idx] = top;
        sky_span[idx] = span;
        sky_count++;

        k = idx + 1;
        while (k < sky_count)
        begin
            prev_end = sky_x[k - 1] + sky_span[k - 1];
            if (sky_x[k] >= prev_end)
                break;
            cut = prev_end - sky_x[k];
            if (cut >= sky_span[k])
            begin
                drop_seg(k);
                continue;
            end
            sky_x[k] += cut;
            sky_span[k] -= cut;
            break;
        end

        k = 0;
        while (k + 1 < sky_count)
        begin
            if (sky_top[k] == sky_top[k + 1])
            begin
                sky_span[k] += sky_span[k + 1];
                drop_seg(k + 1);
            end
            else
                k++;
        end
    endfunction

    // Bottom-left placement of one request; updates the skyline when placed.
    function automatic placement_t place_rect(int unsigned w, int unsigned h, bit turn);
        placement_t  r;
        bit          found;
        int unsigned best_top;
        int unsigned best_span;
        int unsigned best_idx;
        int unsigned best_x;
        int unsigned best_y;
        int unsigned best_w;
        int unsigned best_h;
        bit          best_rot;
        int unsigned y;
        r = '0;
        r.status = ST_NOFIT;
        found = 0;
        best_top = 32'hFFFF_FFFF;
        best_span = 32'hFFFF_FFFF;
        best_idx = 0;
        best_x = 0;
        best_y = 0;
        best_w = 0;
        best_h = 0;
        best_rot = 0;
        if (w == 0 || h == 0)
            return r;
        for (int unsigned i = 0; i < sky_count; i++)
        begin
            if (shape_fits(i, w, h, y))
            begin
                if (y + h < best_top || (y + h == best_top && sky_span[i] < best_span))
                begin
                    found = 1;
                    best_top = y + h;
                    best_span = sky_span[i];
                    best_idx = i;
                    best_x = sky_x[i];
                    best_y = y;
                    best_w = w;
                    best_h = h;
                    best_rot = 0;
                end
            end
            if (turn && shape_fits(i, h, w, y))
            begin
                if (y + w < best_top || (y + w == best_top && sky_span[i] < best_span))
                begin
                    found = 1;
                    best_top = y + w;
                    best_span = sky_span[i];
                    best_idx = i;
                    best_x = sky_x[i];
                    best_y = y;
                    best_w = h;
                    best_h = w;
                    best_rot = 1;
                end
            end
        end
        if (!found)
            return r;
        if (sky_count >= SEG_DEPTH)
        begin
            r.status = ST_FULL;
            return r;
        end
        raise_sky(best_idx, best_x, best_y + best_h, best_w);
        r.status = ST_PLACED;
        r.x_min = best_x[14:0];
        r.y_min = best_y[14:0];
        r.x_max = 15'(best_x + best_w);
        r.y_max = 15'(best_y + best_h);
        r.rotated = best_rot;
        return r;
    endfunction

    function automatic placement_t mk_place(logic [1:0] st, int unsigned x0, int unsigned y0,
                                            int unsigned x1, int unsigned y1, bit rot);
        placement_t p;
        p.status = st;
        p.x_min = x0[14:0];
        p.y_min = y0[14:0];
        p.x_max = x1[14:0];
        p.y_max = y1[14:0];
        p.rotated = rot;
        return p;
    endfunction

    // Register write, issued only once every result has come back.
    task automatic write_reg(logic [0:0] idx, logic [14:0] val);
        while (pending_places.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_BIN_WIDTH)
            bin_w = val;
        else
            bin_h = val;
        restart_sky();
    endtask

    // Send one request beat; the predictor runs at acceptance.
    task automatic send_rect(logic [14:0] w, logic [14:0] h, bit rot, bit typed,
                             placement_t want);
        placement_t got;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tdata = {1'b0, rot, h, w};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        got = place_rect(w, h, rot);
        pending_places = {pending_places, (typed ? want : got)};
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Receiver stalls.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Result checker.
    always @(posedge clk)
    begin
        placement_t act;
        placement_t exp_p;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.status = m_tdata[1:0];
            act.x_min = m_tdata[16:2];
            act.y_min = m_tdata[31:17];
            act.x_max = m_tdata[46:32];
            act.y_max = m_tdata[61:47];
            act.rotated = m_tdata[62];
            if (pending_places.size() == 0)
            begin
                failed = 1;
                $display("%0t: unexpected result beat %h", $realtime, m_tdata);
            end
            else
            begin
                exp_p = pending_places.pop_front();
                if (act != exp_p)
                begin
                    failed = 1;
                    $display("%0t: mismatch expected st=%0d x=%0d..%0d y=%0d..%0d rot=%0d",
                             $realtime, exp_p.status, exp_p.x_min, exp_p.x_max,
                             exp_p.y_min, exp_p.y_max, exp_p.rotated);
                    $display("%0t:          actual   st=%0d x=%0d..%0d y=%0d..%0d rot=%0d",
                             $realtime, act.status, act.x_min, act.x_max,
                             act.y_min, act.y_max, act.rotated);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Small rectangle sized against the current bin, with some zero and full-range ones.
    task automatic send_random_rect();
        int unsigned pick;
        int unsigned lim;
        logic [14:0] w;
        logic [14:0] h;
        pick = $urandom_range(99);
        lim = (bin_w > bin_h ? bin_w : bin_h) / 3 + 1;
        if (lim > 32767)
            lim = 32767;
        w = 15'($urandom_range(1, lim));
        h = 15'($urandom_range(1, lim));
        if (pick < 5)
            w = 0;
        else if (pick < 10)
            h = 0;
        else if (pick < 17)
        begin
            w = 15'($urandom);
            h = 15'($urandom);
        end
        send_rect(w, h, 1'($urandom_range(1)), 0, '0);
    endtask

    initial
    begin
        row_t rows[$];
        row_t r;
        int   sent;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        failed = 0;
        cycles = 0;
        send_idle_pct = 29;
        recv_idle_pct = 81;
        bin_w = 0;
        bin_h = 0;
        restart_sky();

        // Directed table: bin extremes, zero sizes, rotation and no-fit cases.
        r = '{default: '0};
        r.w = 5; r.h = 5; r.typed = 1; r.want = mk_place(ST_NOFIT, 0, 0, 0, 0, 0);
        rows = {rows, r};
        r = '{default: '0}; r.is_cfg = 1; r.reg_idx = REG_BIN_WIDTH; r.reg_val = 15'h7FFF;
        rows = {rows, r};
        r.reg_idx = REG_BIN_HEIGHT;
        rows = {rows, r};
        r = '{default: '0};
        r.w = 15'h7FFF; r.h = 15'h7FFF; r.rot = 1; r.typed = 1;
        r.want = mk_place(ST_PLACED, 0, 0, 32767, 32767, 0);
        rows = {rows, r};
        r = '{default: '0};
        r.w = 1; r.h = 1; r.rot = 1; r.typed = 1; r.want = mk_place(ST_NOFIT, 0, 0, 0, 0, 0);
        rows = {rows, r};
        r = '{default: '0}; r.is_cfg = 1; r.reg_idx = REG_BIN_WIDTH; r.reg_val = 20;
        rows = {rows, r};
        r.reg_idx = REG_BIN_HEIGHT; r.reg_val = 10;
        rows = {rows, r};
        r = '{default: '0};
        r.w = 0; r.h = 5; r.typed = 1; r.want = mk_place(ST_NOFIT, 0, 0, 0, 0, 0);
        rows = {rows, r};
        r.w = 5; r.h = 0; r.rot = 1;
        rows = {rows, r};
        r.w = 30; r.h = 2;
        rows = {rows, r};
        r = '{default: '0};
        r.w = 12; r.h = 2; r.typed = 1; r.want = mk_place(ST_PLACED, 0, 0, 12, 2, 0);
        rows = {rows, r};
        r = '{default: '0};
        r.w = 10; r.h = 3;
        rows = {rows, r};
        r.w = 8; r.h = 15; r.rot = 1;
        rows = {rows, r};
        r.w = 2; r.h = 2;
        rows = {rows, r};
        r.w = 7; r.h = 1;
        rows = {rows, r};
        r.w = 3; r.h = 4;
        rows = {rows, r};
        r.w = 20; r.h = 20;
        rows = {rows, r};
        r = '{default: '0}; r.is_cfg = 1; r.reg_idx = REG_BIN_WIDTH; r.reg_val = 0;
        rows = {rows, r};
        r = '{default: '0};
        r.w = 1; r.h = 1; r.rot = 1; r.typed = 1; r.want = mk_place(ST_NOFIT, 0, 0, 0, 0, 0);
        rows = {rows, r};
        r = '{default: '0}; r.is_cfg = 1; r.reg_idx = REG_BIN_WIDTH; r.reg_val = 15'h7FFF;
        rows = {rows, r};
        r.reg_idx = REG_BIN_HEIGHT; r.reg_val = 1;
        rows = {rows, r};
        r = '{default: '0};
        r.w = 15'h7FFF; r.h = 1; r.typed = 1; r.want = mk_place(ST_PLACED, 0, 0, 32767, 1, 0);
        rows = {rows, r};

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
                send_rect(rows[i].w, rows[i].h, rows[i].rot, rows[i].typed, rows[i].want);
        end

        // Fill the segment store: one-wide columns of alternating height never merge.
        write_reg(REG_BIN_WIDTH, 15'd300);
        write_reg(REG_BIN_HEIGHT, 15'd100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < SEG_DEPTH + 2; i++)
            send_rect(15'd1, (i % 2) ? 15'd2 : 15'd1, 0, 0, '0);
        send_rect(15'd0, 15'd1, 1, 1, mk_place(ST_NOFIT, 0, 0, 0, 0, 0));

        // Random phases on small bins, restarted often to keep the skyline short.
        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 29 : 0;
            while (sent < RAND_ITEMS * (ph + 1) / 3)
            begin
                case ($urandom_range(9))
                    0:       write_reg(REG_BIN_WIDTH, 15'($urandom_range(200, 32767)));
                    1:       write_reg(REG_BIN_WIDTH, 15'($urandom_range(0, 3)));
                    default: write_reg(REG_BIN_WIDTH, 15'($urandom_range(4, 64)));
                endcase
                case ($urandom_range(9))
                    0:       write_reg(REG_BIN_HEIGHT, 15'($urandom_range(200, 32767)));
                    1:       write_reg(REG_BIN_HEIGHT, 15'($urandom_range(0, 3)));
                    default: write_reg(REG_BIN_HEIGHT, 15'($urandom_range(4, 64)));
                endcase
                repeat ($urandom_range(15, 40))
                begin
                    send_random_rect();
                    sent++;
                end
            end
        end

        while (pending_places.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- skyline_rect_packer.f -----
sv/srp_pkg.sv
sv/srp_seg_mem.sv
sv/srp_engine.sv
sv/skyline_rect_packer.sv
test/skyline_rect_packer_tb.sv
